// ===== rtl/ppbt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppbt_pkg
// Shared constants and codes for the packet pacer with burst tokens.
// ----------------------------------------------------------------------------
`default_nettype none

package ppbt_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int MODE_W    = 2;
    localparam int NOW_W     = 48;
    localparam int BIF_W     = 32;
    localparam int PKT_W     = 16;
    localparam int WIN_W     = 32;
    localparam int RATE_W    = 40;
    localparam int WAIT_W    = 48;
    localparam int TOK_W     = 4;
    localparam int GRAN_W    = 16;
    localparam int SEG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 40;

    // divider operand width: bytes * 8e6 fits in 40 bits, so does the rate
    localparam int DIV_BITS  = 40;
    localparam int US_X8_W   = 23;

    localparam logic [US_X8_W-1:0] MICROS_PER_SEC_X8 = US_X8_W'(8000000);
    localparam logic [TOK_W-1:0]   INITIAL_BURST     = TOK_W'(10);

    localparam logic [RATE_W-1:0] MAX_RATE_RST = '0;
    localparam logic [TOK_W-1:0]  BURST_LIM_RST = INITIAL_BURST;
    localparam logic [GRAN_W-1:0] GRAN_RST = GRAN_W'(1000);
    localparam logic [SEG_W-1:0]  SEG_RST = SEG_W'(1460);

    localparam logic [MODE_W-1:0] MODE_SENT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG       = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/packet_pacer_burst_tokens_top.sv =====
// ----------------------------------------------------------------------------
// packet_pacer_burst_tokens_top
// Packet pacer with burst tokens, built around one shared serial divider.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   s_       | s_valid / s_ready  | mode, now, in-flight, size, controller info
//   m_       | m_valid / m_ready  | wait_us, blocked, tokens_left
//   cfg_     | cfg_valid/cfg_ready| cfg_addr, cfg_data
//
// One item at a time. Queries and congestion events do not use the divider; a
// paced send runs the 40-step restoring divider for the transfer delay, and a
// send that refills tokens first runs it for the window division. The result
// register frees the input side: a new item is taken while the last result
// waits. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_pacer_burst_tokens_top #(
    parameter int TIME_BITS = ppbt_pkg::TIME_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [ppbt_pkg::MODE_W-1:0]         s_mode,
    input  wire  [ppbt_pkg::NOW_W-1:0]          s_now_us,
    input  wire  [ppbt_pkg::BIF_W-1:0]          s_bytes_in_flight,
    input  wire  [ppbt_pkg::PKT_W-1:0]          s_packet_bytes,
    input  wire                                 s_retransmittable,
    input  wire                                 s_in_recovery,
    input  wire  [ppbt_pkg::WIN_W-1:0]          s_window_bytes,
    input  wire  [ppbt_pkg::RATE_W-1:0]         s_sender_rate_bps,
    input  wire                                 s_sender_blocked,
    input  wire                                 s_losses_present,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [ppbt_pkg::WAIT_W-1:0]         m_wait_us,
    output logic                                m_blocked,
    output logic [ppbt_pkg::TOK_W-1:0]          m_tokens_left,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ppbt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire  [ppbt_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int DB    = ppbt_pkg::DIV_BITS;
    localparam int CNT_W = $clog2(DB);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DB - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TOKEN,
        S_MUL,
        S_DIV,
        S_SUM,
        S_APPLY,
        S_QCMP,
        S_DONE
    } state_t;

    typedef logic [TIME_BITS-1:0] time_t;

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    // configuration
    logic [ppbt_pkg::RATE_W-1:0] max_rate_reg;
    logic [ppbt_pkg::TOK_W-1:0]  burst_lim_reg;
    logic [ppbt_pkg::GRAN_W-1:0] gran_reg;
    logic [ppbt_pkg::SEG_W-1:0]  seg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rate_reg  <= ppbt_pkg::MAX_RATE_RST;
            burst_lim_reg <= ppbt_pkg::BURST_LIM_RST;
            gran_reg      <= ppbt_pkg::GRAN_RST;
            seg_reg       <= ppbt_pkg::SEG_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                ppbt_pkg::CFG_MAX_RATE:  max_rate_reg  <= cfg_data[ppbt_pkg::RATE_W-1:0];
                ppbt_pkg::CFG_BURST_LIM: burst_lim_reg <= cfg_data[ppbt_pkg::TOK_W-1:0];
                ppbt_pkg::CFG_GRAN:      gran_reg      <= cfg_data[ppbt_pkg::GRAN_W-1:0];
                ppbt_pkg::CFG_SEG:       seg_reg       <= cfg_data[ppbt_pkg::SEG_W-1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg;

    // latched item
    logic [ppbt_pkg::MODE_W-1:0] mode_reg;
    time_t                       now_reg;
    logic                        bif_zero_reg;
    logic [ppbt_pkg::PKT_W-1:0]  pkt_reg;
    logic                        retx_reg;
    logic                        recov_reg;
    logic [ppbt_pkg::WIN_W-1:0]  win_reg;
    logic [ppbt_pkg::RATE_W-1:0] rate_reg;
    logic                        sblk_reg;
    logic                        loss_reg;

    // pacer state
    logic [ppbt_pkg::TOK_W-1:0]  tokens_reg;
    time_t                       ideal_reg;
    time_t                       last_del_reg;
    logic                        delayed_reg;

    // working registers
    time_t                       sum_a_reg;
    time_t                       sum_b_reg;
    time_t                       delay_reg;
    time_t                       wait_reg;
    logic                        blk_reg;
    logic [DB-1:0]               prod_reg;

    // shared divider
    logic [DB-1:0]               div_quot_reg;
    logic [DB-1:0]               div_rem_reg;
    logic [DB-1:0]               div_den_reg;
    logic [CNT_W-1:0]            div_cnt_reg;
    logic                        div_refill_reg;

    logic [DB:0]                 rem_sh;
    logic                        div_ge;
    logic [DB-1:0]               rem_nx;
    logic [DB-1:0]               quot_nx;
    logic [ppbt_pkg::RATE_W-1:0] rate_eff;

    always_comb begin
        rem_sh  = {div_rem_reg, div_quot_reg[DB-1]};
        div_ge  = rem_sh >= {1'b0, div_den_reg};
        rem_nx  = div_ge ? DB'(rem_sh - {1'b0, div_den_reg}) : rem_sh[DB-1:0];
        quot_nx = {div_quot_reg[DB-2:0], div_ge};
    end

    assign rate_eff = (max_rate_reg != '0 && max_rate_reg < rate_reg) ? max_rate_reg
                                                                     : rate_reg;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid        <= 1'b0;
            m_wait_us      <= '0;
            m_blocked      <= 1'b0;
            m_tokens_left  <= '0;
            mode_reg       <= '0;
            now_reg        <= '0;
            bif_zero_reg   <= 1'b0;
            pkt_reg        <= '0;
            retx_reg       <= 1'b0;
            recov_reg      <= 1'b0;
            win_reg        <= '0;
            rate_reg       <= '0;
            sblk_reg       <= 1'b0;
            loss_reg       <= 1'b0;
            tokens_reg     <= ppbt_pkg::INITIAL_BURST;
            ideal_reg      <= '0;
            last_del_reg   <= '0;
            delayed_reg    <= 1'b0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            delay_reg      <= '0;
            wait_reg       <= '0;
            blk_reg        <= 1'b0;
            prod_reg       <= '0;
            div_quot_reg   <= '0;
            div_rem_reg    <= '0;
            div_den_reg    <= '0;
            div_cnt_reg    <= '0;
            div_refill_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != S_DONE) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg     <= s_mode;
                        now_reg      <= TIME_BITS'(s_now_us);
                        bif_zero_reg <= (s_bytes_in_flight == '0);
                        pkt_reg      <= s_packet_bytes;
                        retx_reg     <= s_retransmittable;
                        recov_reg    <= s_in_recovery;
                        win_reg      <= s_window_bytes;
                        rate_reg     <= s_sender_rate_bps;
                        sblk_reg     <= s_sender_blocked;
                        loss_reg     <= s_losses_present;
                        wait_reg     <= '0;
                        blk_reg      <= 1'b0;
                        state_reg    <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    state_reg <= S_DONE;
                    case (mode_reg)
                        ppbt_pkg::MODE_SENT: begin
                            if (retx_reg) begin
                                state_reg <= S_TOKEN;
                                if (bif_zero_reg && !recov_reg) begin
                                    if (seg_reg == '0) begin
                                        tokens_reg <= burst_lim_reg;
                                    end else begin
                                        div_quot_reg   <= DB'(win_reg);
                                        div_rem_reg    <= '0;
                                        div_den_reg    <= DB'(seg_reg);
                                        div_cnt_reg    <= '0;
                                        div_refill_reg <= 1'b1;
                                        state_reg      <= S_DIV;
                                    end
                                end
                            end
                        end
                        ppbt_pkg::MODE_QUERY: begin
                            if (sblk_reg) begin
                                blk_reg <= 1'b1;
                            end else if (tokens_reg == '0 && !bif_zero_reg) begin
                                sum_a_reg <= sat_add(now_reg, TIME_BITS'(gran_reg));
                                state_reg <= S_QCMP;
                            end
                        end
                        ppbt_pkg::MODE_CONG: begin
                            if (loss_reg) begin
                                tokens_reg <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_TOKEN: begin
                    if (tokens_reg != '0) begin
                        tokens_reg   <= tokens_reg - 1'b1;
                        delayed_reg  <= 1'b0;
                        last_del_reg <= '0;
                        ideal_reg    <= '0;
                        state_reg    <= S_DONE;
                    end else begin
                        prod_reg    <= DB'(pkt_reg * ppbt_pkg::MICROS_PER_SEC_X8);
                        div_den_reg <= DB'(rate_eff);
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (div_den_reg == '0) begin
                        delay_reg <= '0;
                        state_reg <= S_SUM;
                    end else begin
                        div_quot_reg   <= prod_reg;
                        div_rem_reg    <= '0;
                        div_cnt_reg    <= '0;
                        div_refill_reg <= 1'b0;
                        state_reg      <= S_DIV;
                    end
                end
                S_DIV: begin
                    div_quot_reg <= quot_nx;
                    div_rem_reg  <= rem_nx;
                    div_cnt_reg  <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CNT_LAST) begin
                        if (div_refill_reg) begin
                            tokens_reg <= (quot_nx < DB'(burst_lim_reg)) ?
                                          quot_nx[ppbt_pkg::TOK_W-1:0] : burst_lim_reg;
                            state_reg  <= S_TOKEN;
                        end else begin
                            delay_reg <= TIME_BITS'(quot_nx);
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    sum_a_reg <= sat_add(ideal_reg, delay_reg);
                    sum_b_reg <= sat_add(delayed_reg ? last_del_reg : now_reg, delay_reg);
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (delayed_reg) begin
                        ideal_reg <= sum_a_reg;
                        // catching up and not app limited: stay in delayed mode
                        if (sum_a_reg <= now_reg &&
                            !(last_del_reg != '0 && now_reg > sum_b_reg)) begin
                            last_del_reg <= now_reg;
                        end else begin
                            delayed_reg  <= 1'b0;
                            last_del_reg <= '0;
                        end
                    end else begin
                        ideal_reg <= (sum_a_reg > sum_b_reg) ? sum_a_reg : sum_b_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_QCMP: begin
                    if (ideal_reg > sum_a_reg) begin
                        delayed_reg <= 1'b1;
                        wait_reg    <= ideal_reg - now_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_wait_us     <= ppbt_pkg::WAIT_W'(wait_reg);
                        m_blocked     <= blk_reg;
                        m_tokens_left <= tokens_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion step");

    a_last_delayed_needs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        last_del_reg != '0 |-> delayed_reg)
        else $error("last delayed send time kept without delayed flag");

    a_blocked_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_blocked |-> m_wait_us == '0)
        else $error("blocked result carries a wait");

    a_div_done_in_time: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && div_cnt_reg == CNT_LAST |=> state_reg != S_DIV)
        else $error("divider ran past its last step");

endmodule

`default_nettype wire
